>>> design/rlpg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rlpg_pkg;

	localparam int RAM_WORDS    = 2048;
	localparam int RAM_AW       = $clog2(RAM_WORDS);
	localparam int BANK_AW      = RAM_AW + 1;
	localparam int PAT_LINES    = 512;
	localparam int PAT_COLS     = 512;
	localparam int PAT_HALF_AW  = $clog2(PAT_LINES / 2) + $clog2(PAT_COLS);
	localparam int SCREEN_LINES = 224;
	localparam int Q_DEPTH      = 4;
	localparam int Q_PW         = $clog2(Q_DEPTH);
	localparam int Q_CW         = $clog2(Q_DEPTH + 1);

	localparam logic [11:0] ORIGIN_X = 12'h5f8;

	localparam logic [2:0]  RST_ROAD_MODE     = 3'd0;
	localparam logic [10:0] RST_ROAD_COLOUR   = 11'h400;
	localparam logic [10:0] RST_BACKDROP      = 11'h420;
	localparam logic [10:0] RST_SOLID_COLOUR  = 11'h780;
	localparam logic [11:0] RST_SCROLL_OFFSET = 12'h000;
	localparam logic [11:0] RST_SCREEN_SHIFT  = 12'h000;

	// priority maps, indexed by road 0 pixel, bit selected by road 1 pixel
	localparam logic [7:0] PRIO_A [8] = '{8'h80, 8'h81, 8'h81, 8'h87, 8'h00, 8'h00, 8'h00, 8'h00};
	localparam logic [7:0] PRIO_B [8] = '{8'h81, 8'h81, 8'h81, 8'h8f, 8'h00, 8'h00, 8'h00, 8'h80};

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_SWAP   = 2'd1,
		OP_LOAD   = 2'd2,
		OP_RENDER = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_ROAD_MODE     = 3'd0,
		REG_ROAD_COLOUR   = 3'd1,
		REG_BACKDROP      = 3'd2,
		REG_SOLID_COLOUR  = 3'd3,
		REG_SCROLL_OFFSET = 3'd4,
		REG_SCREEN_SHIFT  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [2:0]  road_mode;
		logic [10:0] road_colour_base;
		logic [10:0] backdrop_colour_base;
		logic [10:0] solid_colour_base;
		logic [11:0] scroll_offset;
		logic [11:0] screen_shift;
	} cfg_t;

	typedef struct packed {
		op_t         op;
		logic [10:0] word_address;
		logic [15:0] word_value;
		logic [8:0]  pattern_line;
		logic [8:0]  pattern_column;
		logic [2:0]  pattern_value;
		logic [7:0]  scan_line;
		logic [9:0]  screen_column;
		logic        offscreen;
	} item_t;

	typedef struct packed {
		logic clearing;
		logic busy;
	} back_status_t;

endpackage
`default_nettype wire

>>> design/rlpg_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rlpg_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [10:0] word_address;
	logic [15:0] word_value;
	logic [8:0]  pattern_line;
	logic [8:0]  pattern_column;
	logic [1:0]  pattern_value;
	logic [7:0]  scan_line;
	logic [9:0]  screen_column;
	modport source (output valid, kind, word_address, word_value, pattern_line,
		pattern_column, pattern_value, scan_line, screen_column, input ready);
	modport sink (input valid, kind, word_address, word_value, pattern_line,
		pattern_column, pattern_value, scan_line, screen_column, output ready);
endinterface

interface rlpg_out_if;
	logic        valid;
	logic        ready;
	logic [10:0] pixel_colour;
	logic        colour_written;
	modport source (output valid, pixel_colour, colour_written, input ready);
	modport sink (input valid, pixel_colour, colour_written, output ready);
endinterface

interface rlpg_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> design/road_layer_pixel_generator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Road layer pixel generator.
// items  : input transactions, one per clock while ready; kind selects a road RAM word write,
//          a bank swap, a pattern pixel load or a render of one lores pixel.
// pixels : one output transaction per render (colour and written flag); other
//          kinds give none.
// cfg    : register writes, always ready; write only while the block is idle.
// Throughput is one transaction per clock while pixels is not stalled, set by the
// four-stage lookup pipeline (line words, scroll/colour words, pattern pixel,
// colour); each road RAM read pair has its own copy of the RAM.
// A four-entry queue sits between the input side and the pipeline.
// Reset: road RAM is swept to zero, one word per cycle over all 4096 words; items
// is held not ready during the sweep. The pattern store is not cleared.
// When pixels stalls, the whole pipeline holds and the queue fills, after which
// items drops ready.
module road_layer_pixel_generator_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rlpg_cfg_if.sink   cfg,
	rlpg_in_if.sink    items,
	rlpg_out_if.source pixels
);
	rlpg_pkg::cfg_t         cfg_q;
	rlpg_pkg::item_t        push_item, head;
	rlpg_pkg::back_status_t status;
	logic                   push, pop, head_valid, q_full;

	assign cfg.ready = 1'b1;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.road_mode            <= rlpg_pkg::RST_ROAD_MODE;
			cfg_q.road_colour_base     <= rlpg_pkg::RST_ROAD_COLOUR;
			cfg_q.backdrop_colour_base <= rlpg_pkg::RST_BACKDROP;
			cfg_q.solid_colour_base    <= rlpg_pkg::RST_SOLID_COLOUR;
			cfg_q.scroll_offset        <= rlpg_pkg::RST_SCROLL_OFFSET;
			cfg_q.screen_shift         <= rlpg_pkg::RST_SCREEN_SHIFT;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				rlpg_pkg::REG_ROAD_MODE:     cfg_q.road_mode            <= cfg.data[2:0];
				rlpg_pkg::REG_ROAD_COLOUR:   cfg_q.road_colour_base     <= cfg.data[10:0];
				rlpg_pkg::REG_BACKDROP:      cfg_q.backdrop_colour_base <= cfg.data[10:0];
				rlpg_pkg::REG_SOLID_COLOUR:  cfg_q.solid_colour_base    <= cfg.data[10:0];
				rlpg_pkg::REG_SCROLL_OFFSET: cfg_q.scroll_offset        <= cfg.data[11:0];
				rlpg_pkg::REG_SCREEN_SHIFT:  cfg_q.screen_shift         <= cfg.data[11:0];
				default: ;
			endcase
		end
	end

	// front: classify and queue
	rlpg_front u_front (
		.items     (items),
		.q_full    (q_full),
		.status    (status),
		.push      (push),
		.push_item (push_item)
	);

	rlpg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (q_full)
	);

	// back: RAM lookups and colour
	rlpg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.status     (status),
		.pixels     (pixels)
	);

	// no transaction in during the RAM sweep
	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		status.clearing |-> !items.ready)
		else $error("input accepted during RAM sweep");

	// pipeline is empty while sweeping
	a_clear_no_output: assert property (@(posedge clk) disable iff (!arst_n)
		status.clearing |-> !pixels.valid && !status.busy)
		else $error("pipeline active during RAM sweep");

	// a transparent pixel carries colour zero
	a_transparent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pixels.valid && !pixels.colour_written |-> pixels.pixel_colour == 11'd0)
		else $error("transparent pixel with non-zero colour");
endmodule
`default_nettype wire

>>> design/rlpg_front.sv
`timescale 1ns / 1ps
`default_nettype none
module rlpg_front (
	rlpg_in_if.sink              items,
	input  wire logic            q_full,
	input  rlpg_pkg::back_status_t status,
	output logic                 push,
	output rlpg_pkg::item_t      push_item
);
	logic stripe;

	assign items.ready = !q_full && !status.clearing;
	assign push        = items.valid && items.ready;

	// value 3 in columns 248..255 is the centre stripe
	assign stripe = (items.pattern_column[8:3] == 6'b011111) && (items.pattern_value == 2'd3);

	always_comb begin
		push_item                = '0;
		push_item.op             = rlpg_pkg::op_t'(items.kind);
		push_item.word_address   = items.word_address;
		push_item.word_value     = items.word_value;
		push_item.pattern_line   = items.pattern_line;
		push_item.pattern_column = items.pattern_column;
		push_item.pattern_value  = stripe ? 3'd7 : {1'b0, items.pattern_value};
		push_item.scan_line      = items.scan_line;
		push_item.screen_column  = items.screen_column;
		push_item.offscreen      = {1'b0, items.scan_line} >= 9'(rlpg_pkg::SCREEN_LINES);
	end
endmodule
`default_nettype wire

>>> design/rlpg_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module rlpg_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  rlpg_pkg::item_t      push_item,
	input  wire logic            pop,
	output rlpg_pkg::item_t      head,
	output logic                 head_valid,
	output logic                 full
);
	rlpg_pkg::item_t                entry_q [rlpg_pkg::Q_DEPTH];
	logic [rlpg_pkg::Q_PW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [rlpg_pkg::Q_CW-1:0]      count_q;

	assign head       = entry_q[rd_ptr_q];
	assign head_valid = count_q != '0;
	assign full       = count_q == rlpg_pkg::Q_CW'(rlpg_pkg::Q_DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

>>> design/rlpg_back.sv
`timescale 1ns / 1ps
`default_nettype none
module rlpg_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  rlpg_pkg::cfg_t         cfg,
	input  rlpg_pkg::item_t        head,
	input  wire logic              head_valid,
	output logic                   pop,
	output rlpg_pkg::back_status_t status,
	rlpg_out_if.source             pixels
);
	function automatic logic [10:0] road_colour(input logic road, input logic b9,
		input logic [3:0] nib, input logic [3:0] hi, input logic [2:0] pix,
		input logic [10:0] rcb, input logic [10:0] bcb);
		logic [10:0] base0;
		logic [10:0] res;
		base0 = rcb ^ {7'd0, road, 3'd0};
		case (pix)
			3'd0:    res = base0 ^ {10'd0, nib[0]};
			3'd1:    res = base0 ^ 11'd2 ^ {10'd0, nib[1]};
			3'd2:    res = base0 ^ 11'd4 ^ {10'd0, nib[2]};
			3'd7:    res = base0 ^ 11'd6 ^ {10'd0, nib[3]};
			default: res = b9 ? (base0 ^ {10'd0, nib[0]})
				: (bcb ^ {6'd0, road, 4'd0} ^ {7'd0, hi});
		endcase
		return res;
	endfunction

	function automatic logic PRIO_A_BIT(input logic [2:0] a, input logic [2:0] b);
		logic [7:0] row;
		row = rlpg_pkg::PRIO_A[a];
		return row[b];
	endfunction

	function automatic logic PRIO_B_BIT(input logic [2:0] a, input logic [2:0] b);
		logic [7:0] row;
		row = rlpg_pkg::PRIO_B[a];
		return row[b];
	endfunction

	// road RAM copies, one per pair of read ports
	logic [15:0] ram_a [2 * rlpg_pkg::RAM_WORDS];
	logic [15:0] ram_b [2 * rlpg_pkg::RAM_WORDS];
	logic [15:0] ram_c [2 * rlpg_pkg::RAM_WORDS];
	// pattern halves, road 0 lines and road 1 lines
	logic [2:0]  pat0 [2 ** rlpg_pkg::PAT_HALF_AW];
	logic [2:0]  pat1 [2 ** rlpg_pkg::PAT_HALF_AW];

	logic                          adv;
	logic                          clr_q;
	logic [rlpg_pkg::BANK_AW-1:0]  clr_idx_q;
	logic                          rb_q;
	logic [11:0]                   shift_q;
	logic                          we;
	logic [rlpg_pkg::BANK_AW-1:0]  waddr;
	logic [15:0]                   wdata;

	// stage 1
	logic        r_s1, ld_s1, bk_s1, off_s1;
	logic [7:0]  y_s1;
	logic [9:0]  x_s1;
	logic [8:0]  pl_s1, pc_s1;
	logic [2:0]  pv_s1;
	logic [15:0] d0_s1, d1_s1;
	logic        skip, sol0, sol1;
	logic [15:0] sd;
	logic [8:0]  i0, i1;

	// stage 2
	logic        r_s2, ld_s2, off_s2, skip_s2, sol0_s2, sol1_s2, b90_s2, b91_s2;
	logic [10:0] scol_s2;
	logic [7:0]  ln0_s2, ln1_s2;
	logic [9:0]  x_s2;
	logic [8:0]  pl_s2, pc_s2;
	logic [2:0]  pv_s2;
	logic [15:0] h0_s2, h1_s2, c0_s2, c1_s2;
	logic [11:0] h0n, h1n;
	logic        f0, f1;

	// stage 3
	logic        r_s3, off_s3, skip_s3, f0_s3, f1_s3, b90_s3, b91_s3;
	logic [10:0] scol_s3;
	logic [11:0] c0_s3, c1_s3;
	logic [2:0]  p0_s3, p1_s3;
	logic [2:0]  p0, p1;
	logic [1:0]  ctl;
	logic        pick1;
	logic [10:0] col0, col1, colour;

	// output
	logic        out_v_q;
	logic [10:0] out_colour_q;
	logic        out_written_q;

	assign adv             = !out_v_q || pixels.ready;
	assign pop             = head_valid && adv && !clr_q;
	assign status.clearing = clr_q;
	assign status.busy     = r_s1 || r_s2 || r_s3 || ld_s1 || ld_s2 || out_v_q;

	assign we    = clr_q || (pop && head.op == rlpg_pkg::OP_WRITE);
	assign waddr = clr_q ? clr_idx_q : {~rb_q, head.word_address};
	assign wdata = clr_q ? 16'd0 : head.word_value;

	// clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (&clr_idx_q) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		shift_q <= rlpg_pkg::ORIGIN_X + cfg.screen_shift + cfg.scroll_offset;
	end

	// stage 0: line words of both roads
	always_ff @(posedge clk) begin
		if (we) begin
			ram_a[waddr] <= wdata;
		end
		if (adv) begin
			d0_s1 <= ram_a[{rb_q, 3'b000, head.scan_line}];
			d1_s1 <= ram_a[{rb_q, 3'b001, head.scan_line}];
		end
	end

	// stage 1: solid line test and line indexes
	assign ctl  = cfg.road_mode[1:0];
	assign sol0 = d0_s1[11];
	assign sol1 = d1_s1[11];
	assign skip = (sol0 && sol1) || (ctl == 2'd0 && sol0) || (ctl == 2'd3 && sol1);
	assign sd   = (ctl[1] == 1'b0) ? (sol0 ? d0_s1 : d1_s1) : (sol1 ? d1_s1 : d0_s1);
	assign i0   = cfg.road_mode[2] ? {1'b0, y_s1} : d0_s1[8:0];
	assign i1   = cfg.road_mode[2] ? {1'b1, y_s1} : d1_s1[8:0];

	always_ff @(posedge clk) begin
		if (we) begin
			ram_b[waddr] <= wdata;
		end
		if (adv) begin
			h0_s2 <= ram_b[{bk_s1, 2'b01, i0}];
			h1_s2 <= ram_b[{bk_s1, 2'b10, i1}];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			ram_c[waddr] <= wdata;
		end
		if (adv) begin
			c0_s2 <= ram_c[{bk_s1, 2'b11, i0}];
			c1_s2 <= ram_c[{bk_s1, 2'b11, i1}];
		end
	end

	// stage 2: horizontal positions and pattern pixels
	assign h0n = h0_s2[11:0] - shift_q + {2'b00, x_s2};
	assign h1n = h1_s2[11:0] - shift_q + {2'b00, x_s2};
	assign f0  = sol0_s2 || (h0n[11:9] != 3'd0);
	assign f1  = sol1_s2 || (h1n[11:9] != 3'd0);

	always_ff @(posedge clk) begin
		if (adv && ld_s2 && !pl_s2[8]) begin
			pat0[{pl_s2[7:0], pc_s2}] <= pv_s2;
		end
		if (adv) begin
			p0_s3 <= pat0[{ln0_s2, h0n[8:0]}];
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ld_s2 && pl_s2[8]) begin
			pat1[{pl_s2[7:0], pc_s2}] <= pv_s2;
		end
		if (adv) begin
			p1_s3 <= pat1[{ln1_s2, h1n[8:0]}];
		end
	end

	// stage 3: priority and colour
	assign p0    = f0_s3 ? 3'd3 : p0_s3;
	assign p1    = f1_s3 ? 3'd3 : p1_s3;
	assign col0  = road_colour(1'b0, b90_s3, c0_s3[3:0], c0_s3[11:8], p0,
		cfg.road_colour_base, cfg.backdrop_colour_base);
	assign col1  = road_colour(1'b1, b91_s3, c1_s3[7:4], c1_s3[11:8], p1,
		cfg.road_colour_base, cfg.backdrop_colour_base);

	always_comb begin
		case (ctl)
			2'd0:    pick1 = 1'b0;
			2'd3:    pick1 = 1'b1;
			2'd1:    pick1 = PRIO_A_BIT(p0, p1);
			default: pick1 = PRIO_B_BIT(p0, p1);
		endcase
	end

	assign colour = pick1 ? col1 : col0;

	// payload registers
	always_ff @(posedge clk) begin
		if (adv) begin
			bk_s1   <= rb_q;
			off_s1  <= head.offscreen;
			y_s1    <= head.scan_line;
			x_s1    <= head.screen_column;
			pl_s1   <= head.pattern_line;
			pc_s1   <= head.pattern_column;
			pv_s1   <= head.pattern_value;

			off_s2  <= off_s1;
			skip_s2 <= skip;
			scol_s2 <= {4'd0, sd[6:0]} | cfg.solid_colour_base;
			sol0_s2 <= sol0;
			sol1_s2 <= sol1;
			b90_s2  <= d0_s1[9];
			b91_s2  <= d1_s1[9];
			ln0_s2  <= d0_s1[8:1];
			ln1_s2  <= d1_s1[8:1];
			x_s2    <= x_s1;
			pl_s2   <= pl_s1;
			pc_s2   <= pc_s1;
			pv_s2   <= pv_s1;

			off_s3  <= off_s2;
			skip_s3 <= skip_s2;
			scol_s3 <= scol_s2;
			f0_s3   <= f0;
			f1_s3   <= f1;
			b90_s3  <= b90_s2;
			b91_s3  <= b91_s2;
			c0_s3   <= c0_s2[11:0];
			c1_s3   <= c1_s2[11:0];

			if (off_s3) begin
				out_colour_q  <= 11'd0;
				out_written_q <= 1'b0;
			end else if (skip_s3) begin
				out_colour_q  <= scol_s3;
				out_written_q <= 1'b1;
			end else begin
				out_colour_q  <= colour;
				out_written_q <= 1'b1;
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rb_q    <= 1'b0;
			r_s1    <= 1'b0;
			ld_s1   <= 1'b0;
			r_s2    <= 1'b0;
			ld_s2   <= 1'b0;
			r_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			if (pop && head.op == rlpg_pkg::OP_SWAP) begin
				rb_q <= ~rb_q;
			end
			r_s1    <= pop && head.op == rlpg_pkg::OP_RENDER;
			ld_s1   <= pop && head.op == rlpg_pkg::OP_LOAD;
			r_s2    <= r_s1;
			ld_s2   <= ld_s1;
			r_s3    <= r_s2;
			out_v_q <= r_s3;
		end
	end

	assign pixels.valid          = out_v_q;
	assign pixels.pixel_colour   = out_colour_q;
	assign pixels.colour_written = out_written_q;
endmodule
`default_nettype wire
